// ----- hdl/tcit_pkg.sv -----
// Package for the three-channel interval timer: command, access-order and mode codes,
// request/response structs and sizing constants.
// No dependencies.
package tcit_pkg;

  // Channel count: default and upper bound
  localparam int NUM_CHANNELS_DEF = 3;
  localparam int MAX_CHANNELS     = 3;

  // Byte masks applied to the reload value
  localparam logic [15:0] LO_MASK = 16'h00FF;
  localparam logic [15:0] HI_MASK = 16'hFF00;

  // Control register address
  localparam logic [1:0] CTRL_ADDR = 2'd3;

  // Mode field codes (control word bits 3..1)
  localparam logic [2:0] CW_MODE_RATE   = 3'd2;
  localparam logic [2:0] CW_MODE_SQUARE = 3'd3;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLOCK = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ORD_LATCH = 2'd0,
    ORD_LO    = 2'd1,
    ORD_HI    = 2'd2,
    ORD_LOHI  = 2'd3
  } order_t;

  typedef enum logic [1:0] {
    MODE_ONESHOT = 2'd0,
    MODE_RATE    = 2'd2,
    MODE_SQUARE  = 2'd3
  } mode_t;

  // Decoded per-channel request for one word
  typedef struct packed {
    logic       ctrl;
    logic       wr;
    logic       rd;
    logic       tick;
    logic [7:0] data;
  } tcit_req_t;

  // Per-channel response: read byte and OUT level after the word
  typedef struct packed {
    logic [7:0] rd_data;
    logic       level_nxt;
  } tcit_rsp_t;

endpackage

// ----- hdl/tcit_if.sv -----
// Valid/ready channel interfaces for the interval timer: input word and result word.
// No dependencies.
interface tcit_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [1:0] address;
  logic [7:0] write_data;
  logic       gate;

  modport source (output valid, command, address, write_data, gate, input ready);
  modport sink   (input valid, command, address, write_data, gate, output ready);
endinterface

interface tcit_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic [2:0] out_levels;

  modport source (output valid, read_data, out_levels, input ready);
  modport sink   (input valid, read_data, out_levels, output ready);
endinterface

// ----- hdl/tcit_channel.sv -----
// One 16-bit down counter of the interval timer: control word, byte access and counting.
// Depends on tcit_pkg.
module tcit_channel (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tcit_pkg::tcit_req_t  req,
  output tcit_pkg::tcit_rsp_t  rsp
);
  import tcit_pkg::*;

  mode_t       mode_r,    mode_nxt;
  order_t      order_r,   order_nxt;
  logic        ehw_r,     ehw_nxt;
  logic        ehr_r,     ehr_nxt;
  logic [15:0] reload_r,  reload_nxt;
  logic [15:0] count_r,   count_nxt;
  logic [15:0] latch_r,   latch_nxt;
  logic        lvalid_r,  lvalid_nxt;
  logic        level_r,   level_nxt;
  logic        armed_r,   armed_nxt;

  logic [15:0] lo_set;
  logic [15:0] hi_set;
  logic [15:0] rd_val;
  logic [15:0] cnt_dec;
  logic [7:0]  rd_byte;
  order_t      cw_order;

  assign lo_set   = (reload_r & HI_MASK) | {8'h00, req.data};
  assign hi_set   = (reload_r & LO_MASK) | {req.data, 8'h00};
  assign rd_val   = lvalid_r ? latch_r : count_r;
  assign cnt_dec  = (count_r != 16'd0) ? count_r - 16'd1 : 16'd0;
  assign cw_order = order_t'(req.data[5:4]);

  // Next state for the word addressed to this channel
  always_comb begin
    mode_nxt   = mode_r;
    order_nxt  = order_r;
    ehw_nxt    = ehw_r;
    ehr_nxt    = ehr_r;
    reload_nxt = reload_r;
    count_nxt  = count_r;
    latch_nxt  = latch_r;
    lvalid_nxt = lvalid_r;
    level_nxt  = level_r;
    armed_nxt  = armed_r;
    rd_byte    = 8'h00;

    if (req.ctrl) begin
      // Control word: latch command or new mode/order
      if (cw_order == ORD_LATCH) begin
        latch_nxt  = count_r;
        lvalid_nxt = 1'b1;
      end else begin
        order_nxt = cw_order;
        ehw_nxt   = 1'b0;
        ehr_nxt   = 1'b0;
        armed_nxt = 1'b0;
        unique case (req.data[3:1])
          CW_MODE_RATE:   mode_nxt = MODE_RATE;
          CW_MODE_SQUARE: mode_nxt = MODE_SQUARE;
          default:        mode_nxt = MODE_ONESHOT;
        endcase
        level_nxt = (req.data[3:1] == CW_MODE_RATE) || (req.data[3:1] == CW_MODE_SQUARE);
      end
    end

    if (req.wr) begin
      // Count byte write
      unique case (order_r)
        ORD_LO: begin
          reload_nxt = lo_set;
          count_nxt  = lo_set;
          armed_nxt  = 1'b1;
        end
        ORD_HI: begin
          reload_nxt = hi_set;
          count_nxt  = hi_set;
          armed_nxt  = 1'b1;
        end
        ORD_LOHI: begin
          if (!ehw_r) begin
            reload_nxt = lo_set;
            ehw_nxt    = 1'b1;
            armed_nxt  = 1'b0;
          end else begin
            reload_nxt = hi_set;
            count_nxt  = hi_set;
            armed_nxt  = 1'b1;
            ehw_nxt    = 1'b0;
          end
        end
        ORD_LATCH: ;
      endcase
    end

    if (req.rd) begin
      // Count byte read, from the snapshot when one is held
      unique case (order_r)
        ORD_HI: begin
          lvalid_nxt = 1'b0;
          rd_byte    = rd_val[15:8];
        end
        ORD_LOHI: begin
          if (!ehr_r) begin
            ehr_nxt = 1'b1;
            rd_byte = rd_val[7:0];
          end else begin
            ehr_nxt    = 1'b0;
            lvalid_nxt = 1'b0;
            rd_byte    = rd_val[15:8];
          end
        end
        ORD_LO, ORD_LATCH: begin
          lvalid_nxt = 1'b0;
          rd_byte    = rd_val[7:0];
        end
      endcase
    end

    if (req.tick && armed_r) begin
      // Counter clock edge with gate high
      unique case (mode_r)
        MODE_RATE: begin
          count_nxt = cnt_dec;
          if (cnt_dec == 16'd1) begin
            level_nxt = 1'b0;
          end else if (cnt_dec == 16'd0) begin
            level_nxt = 1'b1;
            count_nxt = reload_r;
          end
        end
        MODE_SQUARE: begin
          count_nxt = (count_r >= 16'd2) ? count_r - 16'd2 : 16'd0;
          if (count_r <= 16'd2) begin
            level_nxt = !level_r;
            count_nxt = reload_r;
          end
        end
        default: begin
          count_nxt = cnt_dec;
          if (cnt_dec == 16'd0) begin
            level_nxt = 1'b1;
            armed_nxt = 1'b0;
          end
        end
      endcase
    end
  end

  // Channel state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_ONESHOT;
      order_r  <= ORD_LATCH;
      ehw_r    <= 1'b0;
      ehr_r    <= 1'b0;
      reload_r <= 16'd0;
      count_r  <= 16'd0;
      latch_r  <= 16'd0;
      lvalid_r <= 1'b0;
      level_r  <= 1'b0;
      armed_r  <= 1'b0;
    end else begin
      mode_r   <= mode_nxt;
      order_r  <= order_nxt;
      ehw_r    <= ehw_nxt;
      ehr_r    <= ehr_nxt;
      reload_r <= reload_nxt;
      count_r  <= count_nxt;
      latch_r  <= latch_nxt;
      lvalid_r <= lvalid_nxt;
      level_r  <= level_nxt;
      armed_r  <= armed_nxt;
    end
  end

  assign rsp.rd_data   = rd_byte;
  assign rsp.level_nxt = level_nxt;

endmodule

// ----- hdl/three_channel_interval_timer.sv -----
// Three-channel interval timer: input word register, per-channel counters, result register.
// A word accepted into the input register is applied to the per-channel counters as it moves on,
// and its result word is captured in the result register, from which the out side takes it.
// Throughput: one word per cycle while the result side takes words; with the result stalled
// the input register takes one more word and then in ready drops until out ready returns.
// Reset (rst_n low, synchronous): both registers empty, all counters, reload values,
// snapshots and toggles zero, all OUT levels low.
// Depends on tcit_pkg, tcit_if and tcit_channel.
module three_channel_interval_timer #(
  parameter int NUM_CHANNELS = tcit_pkg::NUM_CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  tcit_in_if.sink     in_if,
  tcit_out_if.source  out_if
);
  import tcit_pkg::*;

  // Input word register
  logic       s1_valid_r;
  cmd_t       s1_cmd_r;
  logic [1:0] s1_addr_r;
  logic [7:0] s1_data_r;
  logic       s1_gate_r;

  // Result word register
  logic       out_valid_r;
  logic [7:0] out_rd_r;
  logic [2:0] out_lvl_r;

  logic       s1_adv;
  logic       s1_fire;
  logic       in_acc;
  logic [7:0] rd_nxt;
  logic [2:0] lvl_nxt;

  tcit_req_t  req   [MAX_CHANNELS];
  tcit_rsp_t  rsp   [MAX_CHANNELS];
  logic [7:0] rd_or [MAX_CHANNELS + 1];

  assign s1_adv      = !out_valid_r || out_if.ready;
  assign s1_fire     = s1_valid_r && s1_adv;
  assign in_if.ready = !s1_valid_r || s1_adv;
  assign in_acc      = in_if.valid && in_if.ready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r  <= cmd_t'(in_if.command);
      s1_addr_r <= in_if.address;
      s1_data_r <= in_if.write_data;
      s1_gate_r <= in_if.gate;
    end
  end

  // Per-channel decode and counters
  assign rd_or[0] = 8'h00;
  for (genvar i = 0; i < MAX_CHANNELS; i++) begin : g_ch
    if (i < NUM_CHANNELS) begin : g_on
      assign req[i].ctrl = s1_fire && (s1_cmd_r == CMD_WRITE) && (s1_addr_r == CTRL_ADDR)
                           && (s1_data_r[7:6] == 2'(i));
      assign req[i].wr   = s1_fire && (s1_cmd_r == CMD_WRITE) && (s1_addr_r == 2'(i));
      assign req[i].rd   = s1_fire && (s1_cmd_r == CMD_READ) && (s1_addr_r == 2'(i));
      assign req[i].tick = s1_fire && (s1_cmd_r == CMD_CLOCK) && (s1_addr_r == 2'(i))
                           && s1_gate_r;
      assign req[i].data = s1_data_r;

      tcit_channel u_ch (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req[i]),
        .rsp   (rsp[i])
      );
    end else begin : g_off
      assign req[i] = '0;
      assign rsp[i] = '0;
    end
    assign rd_or[i + 1] = rd_or[i] | rsp[i].rd_data;
    assign lvl_nxt[i]   = rsp[i].level_nxt;
  end

  assign rd_nxt = rd_or[MAX_CHANNELS];

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_rd_r  <= rd_nxt;
      out_lvl_r <= lvl_nxt;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.read_data  = out_rd_r;
  assign out_if.out_levels = out_lvl_r;

  // A stalled input word stays put
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r)
    else $error("input word dropped while result stalled");

  // An empty result register never blocks the input side
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_if.ready)
    else $error("input not ready with empty result register");

  // Only a counter read returns a nonzero byte
  a_rd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && !((s1_cmd_r == CMD_READ) && (s1_addr_r != CTRL_ADDR))
    |=> out_if.read_data == 8'h00)
    else $error("nonzero read byte for a word that is not a counter read");

  // Missing channels keep their OUT level low
  a_lvl_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_lvl_r >> NUM_CHANNELS) == 3'd0)
    else $error("OUT level set for a missing channel");

endmodule

// ----- tb/tb_three_channel_interval_timer.sv -----
// Self-checking testbench for the three-channel interval timer: directed words, then random
// program/load/count sequences, with a built-in timer predictor and an in-order result check.
// Depends on tcit_pkg, tcit_if and three_channel_interval_timer.
module tb_three_channel_interval_timer;
  import tcit_pkg::*;

  localparam int CHANS          = NUM_CHANNELS_DEF;
  localparam int RANDOM_WORDS   = 870;
  localparam int IDLE_LIMIT     = 1000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int MAX_REPORTS    = 10;

  // Mode field values beyond the two the package names
  localparam logic [2:0] CW_MODE_ONESHOT = 3'd0;
  localparam logic [2:0] CW_MODE_UNUSED  = 3'd7;

  typedef struct packed {
    logic [7:0] read_data;
    logic [2:0] out_levels;
  } timer_result_t;

  logic clk = 1'b0;
  logic rst_n;

  tcit_in_if  in_if ();
  tcit_out_if out_if ();

  three_channel_interval_timer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Timer state as the predictor sees it
  mode_t       cnt_mode   [MAX_CHANNELS];
  order_t      cnt_order  [MAX_CHANNELS];
  logic        wr_hi_next [MAX_CHANNELS];
  logic        rd_hi_next [MAX_CHANNELS];
  logic [15:0] reload_val [MAX_CHANNELS];
  logic [15:0] count_val  [MAX_CHANNELS];
  logic [15:0] snap_val   [MAX_CHANNELS];
  logic        snap_held  [MAX_CHANNELS];
  logic        out_lvl    [MAX_CHANNELS];
  logic        armed      [MAX_CHANNELS];

  timer_result_t predicted_results[$];
  int err_count    = 0;
  int burst_left   = 0;
  bit burst_gapless = 1'b0;

  function automatic logic [7:0] ctrl_word(logic [1:0] ch, order_t ord, logic [2:0] mfield,
                                           logic bcd);
    return {ch, ord, mfield, bcd};
  endfunction

  // Apply one word to the predicted timer state and return the result word it yields
  function automatic timer_result_t advance_timer(cmd_t cmd, logic [1:0] addr,
                                                  logic [7:0] data, logic gate);
    timer_result_t r;
    logic [1:0]  cw_ch;
    logic [2:0]  cw_mode;
    logic [15:0] v;
    logic [15:0] c;
    logic [15:0] lo_set;
    logic [15:0] hi_set;
    r = '0;
    case (cmd)
      CMD_WRITE: begin
        if (addr == CTRL_ADDR) begin
          cw_ch   = data[7:6];
          cw_mode = data[3:1];
          if (cw_ch < CHANS) begin
            if (order_t'(data[5:4]) == ORD_LATCH) begin
              // latch: snapshot, order untouched
              snap_val[cw_ch]  = count_val[cw_ch];
              snap_held[cw_ch] = 1'b1;
            end else begin
              if (cw_mode == CW_MODE_RATE)        cnt_mode[cw_ch] = MODE_RATE;
              else if (cw_mode == CW_MODE_SQUARE) cnt_mode[cw_ch] = MODE_SQUARE;
              else                                cnt_mode[cw_ch] = MODE_ONESHOT;
              cnt_order[cw_ch]  = order_t'(data[5:4]);
              armed[cw_ch]      = 1'b0;
              wr_hi_next[cw_ch] = 1'b0;
              rd_hi_next[cw_ch] = 1'b0;
              out_lvl[cw_ch]    = (cnt_mode[cw_ch] != MODE_ONESHOT);
            end
          end
        end else if (addr < CHANS) begin
          lo_set = (reload_val[addr] & HI_MASK) | {8'h00, data};
          hi_set = (reload_val[addr] & LO_MASK) | {data, 8'h00};
          case (cnt_order[addr])
            ORD_LO: begin
              reload_val[addr] = lo_set;
              count_val[addr]  = lo_set;
              armed[addr]      = 1'b1;
            end
            ORD_HI: begin
              reload_val[addr] = hi_set;
              count_val[addr]  = hi_set;
              armed[addr]      = 1'b1;
            end
            ORD_LOHI: begin
              if (!wr_hi_next[addr]) begin
                reload_val[addr] = lo_set;
                wr_hi_next[addr] = 1'b1;
                armed[addr]      = 1'b0;
              end else begin
                reload_val[addr] = hi_set;
                count_val[addr]  = hi_set;
                armed[addr]      = 1'b1;
                wr_hi_next[addr] = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      CMD_READ: begin
        if (addr != CTRL_ADDR && addr < CHANS) begin
          v = snap_held[addr] ? snap_val[addr] : count_val[addr];
          case (cnt_order[addr])
            ORD_HI: begin
              snap_held[addr] = 1'b0;
              r.read_data     = v[15:8];
            end
            ORD_LOHI: begin
              if (!rd_hi_next[addr]) begin
                rd_hi_next[addr] = 1'b1;
                r.read_data      = v[7:0];
              end else begin
                rd_hi_next[addr] = 1'b0;
                snap_held[addr]  = 1'b0;
                r.read_data      = v[15:8];
              end
            end
            default: begin
              snap_held[addr] = 1'b0;
              r.read_data     = v[7:0];
            end
          endcase
        end
      end
      CMD_CLOCK: begin
        if (addr != CTRL_ADDR && addr < CHANS && gate && armed[addr]) begin
          c = count_val[addr];
          case (cnt_mode[addr])
            MODE_RATE: begin
              if (c != 16'd0) c = c - 16'd1;
              if (c == 16'd1) begin
                out_lvl[addr] = 1'b0;
              end else if (c == 16'd0) begin
                out_lvl[addr] = 1'b1;
                c = reload_val[addr];
              end
            end
            MODE_SQUARE: begin
              c = (c >= 16'd2) ? c - 16'd2 : 16'd0;
              if (c == 16'd0) begin
                out_lvl[addr] = !out_lvl[addr];
                c = reload_val[addr];
              end
            end
            default: begin
              if (c != 16'd0) c = c - 16'd1;
              if (c == 16'd0) begin
                out_lvl[addr] = 1'b1;
                armed[addr]   = 1'b0;
              end
            end
          endcase
          count_val[addr] = c;
        end
      end
      default: ;
    endcase
    for (int i = 0; i < CHANS; i++) r.out_levels[i] = out_lvl[i];
    return r;
  endfunction

  task automatic flag_error(input string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("%s", msg);
  endtask

  // Send one word; bursts of random length separated by random gaps
  task automatic send_word(input cmd_t cmd, input logic [1:0] addr, input logic [7:0] data,
                           input logic gate);
    int gap;
    if (burst_left == 0) begin
      gap = burst_gapless ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_if.valid      <= 1'b1;
    in_if.command    <= cmd;
    in_if.address    <= addr;
    in_if.write_data <= data;
    in_if.gate       <= gate;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    predicted_results.push_back(advance_timer(cmd, addr, data, gate));
    burst_left--;
  endtask

  // Power-on state, ignored words and the order-zero paths
  task automatic test_reset_and_ignored();
    send_word(CMD_READ,  2'd0, 8'h00, 1'b0);
    send_word(CMD_WRITE, 2'd1, 8'hFF, 1'b1);
    send_word(CMD_WRITE, CTRL_ADDR, ctrl_word(2'd0, ORD_LATCH, CW_MODE_ONESHOT, 1'b0), 1'b0);
    send_word(CMD_READ,  2'd0, 8'h00, 1'b0);
    send_word(CMD_CLOCK, CTRL_ADDR, 8'h00, 1'b1);
    send_word(CMD_NOP,   2'd2, 8'hAA, 1'b1);
    send_word(CMD_WRITE, CTRL_ADDR, ctrl_word(2'd3, ORD_LOHI, CW_MODE_SQUARE, 1'b0), 1'b0);
    send_word(CMD_READ,  CTRL_ADDR, 8'h00, 1'b0);
  endtask

  // Unsupported mode field falls back to one-shot; gate low holds the count
  task automatic test_one_shot_count();
    send_word(CMD_WRITE, CTRL_ADDR, ctrl_word(2'd0, ORD_LO, CW_MODE_UNUSED, 1'b0), 1'b0);
    send_word(CMD_WRITE, 2'd0, 8'h02, 1'b0);
    send_word(CMD_CLOCK, 2'd0, 8'h00, 1'b0);
    repeat (3) send_word(CMD_CLOCK, 2'd0, 8'h00, 1'b1);
  endtask

  task automatic test_rate_generator();
    send_word(CMD_WRITE, CTRL_ADDR, ctrl_word(2'd1, ORD_LOHI, CW_MODE_RATE, 1'b0), 1'b0);
    send_word(CMD_WRITE, 2'd1, 8'h03, 1'b0);
    send_word(CMD_WRITE, 2'd1, 8'h00, 1'b0);
    repeat (3) send_word(CMD_CLOCK, 2'd1, 8'h00, 1'b1);
  endtask

  // Square wave with a repeated latch read back in two bytes
  task automatic test_square_wave_and_latch();
    send_word(CMD_WRITE, CTRL_ADDR, ctrl_word(2'd2, ORD_LOHI, CW_MODE_SQUARE, 1'b1), 1'b0);
    send_word(CMD_WRITE, 2'd2, 8'h04, 1'b0);
    send_word(CMD_WRITE, 2'd2, 8'h00, 1'b0);
    repeat (2) send_word(CMD_CLOCK, 2'd2, 8'h00, 1'b1);
    send_word(CMD_WRITE, CTRL_ADDR, ctrl_word(2'd2, ORD_LATCH, CW_MODE_ONESHOT, 1'b0), 1'b0);
    send_word(CMD_CLOCK, 2'd2, 8'h00, 1'b1);
    send_word(CMD_WRITE, CTRL_ADDR, ctrl_word(2'd2, ORD_LATCH, CW_MODE_ONESHOT, 1'b0), 1'b0);
    repeat (2) send_word(CMD_READ, 2'd2, 8'h00, 1'b0);
  endtask

  // Mostly program/load/count sequences, some latch reads, some raw noise
  task automatic test_random_traffic();
    int budget;
    int kind;
    int pick;
    int n;
    int k;
    logic [1:0]  ch;
    order_t      ord;
    logic [15:0] load;
    budget = 0;
    while (budget < RANDOM_WORDS) begin
      kind = $urandom_range(0, 99);
      burst_gapless = ($urandom_range(0, 4) == 0);
      ch = 2'($urandom_range(0, CHANS - 1));
      if (kind < 70) begin
        ord  = order_t'($urandom_range(1, 3));
        load = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 24));
        send_word(CMD_WRITE, CTRL_ADDR,
                  ctrl_word(ch, ord, 3'($urandom), 1'($urandom)), 1'($urandom));
        budget++;
        if (ord == ORD_HI) begin
          send_word(CMD_WRITE, ch, load[15:8], 1'($urandom));
        end else begin
          send_word(CMD_WRITE, ch, load[7:0], 1'($urandom));
          // occasionally leave the high byte out
          if (ord == ORD_LOHI && $urandom_range(0, 9) != 0) begin
            send_word(CMD_WRITE, ch, load[15:8], 1'($urandom));
            budget++;
          end
        end
        budget++;
        n = $urandom_range(1, 30);
        for (k = 0; k < n; k++) begin
          pick = $urandom_range(0, 99);
          if (pick < 80)
            send_word(CMD_CLOCK, ch, 8'($urandom), ($urandom_range(0, 9) != 0));
          else if (pick < 90)
            send_word(CMD_READ, ch, 8'($urandom), 1'($urandom));
          else if (pick < 94)
            send_word(CMD_WRITE, CTRL_ADDR,
                      ctrl_word(ch, ORD_LATCH, 3'($urandom), 1'($urandom)), 1'($urandom));
          else
            send_word(cmd_t'($urandom_range(0, 2)), 2'($urandom_range(0, CHANS - 1)),
                      8'($urandom), 1'($urandom));
        end
        budget += n;
      end else if (kind < 85) begin
        send_word(CMD_WRITE, CTRL_ADDR,
                  ctrl_word(ch, ORD_LATCH, 3'($urandom), 1'($urandom)), 1'($urandom));
        n = $urandom_range(1, 3);
        repeat (n) send_word(CMD_READ, ch, 8'($urandom), 1'($urandom));
        budget += n + 1;
      end else begin
        // raw words, many of them ignored
        n = $urandom_range(1, 6);
        repeat (n)
          send_word(cmd_t'($urandom_range(0, 3)), 2'($urandom), 8'($urandom), 1'($urandom));
        budget += n;
      end
    end
  endtask

  // Result check against the oldest predicted word
  always @(posedge clk) begin
    timer_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (predicted_results.size() == 0) begin
        flag_error($sformatf("unexpected result word: read_data %02h out_levels %03b",
                             out_if.read_data, out_if.out_levels));
      end else begin
        want = predicted_results.pop_front();
        if (out_if.read_data !== want.read_data || out_if.out_levels !== want.out_levels)
          flag_error($sformatf(
            "mismatch: read_data exp %02h got %02h, out_levels exp %03b got %03b",
            want.read_data, out_if.read_data, want.out_levels, out_if.out_levels));
      end
    end
  end

  // Receiver: switches between styles (always ready, random, on/off runs), each kept for a random stretch
  initial begin
    int style_left;
    int style;
    int run_left;
    style_left = 0;
    style      = 0;
    run_left   = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (style_left == 0) begin
        style      = $urandom_range(0, 2);
        style_left = $urandom_range(50, 300);
      end
      style_left--;
      case (style)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= ($urandom_range(0, 3) != 0);
        default: begin
          if (run_left == 0) begin
            out_if.ready <= !out_if.ready;
            run_left = out_if.ready ? $urandom_range(1, 12) : $urandom_range(1, 8);
          end else begin
            run_left--;
          end
        end
      endcase
    end
  end

  // Watchdog on cycles with no word moving on either side
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no word accepted for %0d cycles", idle_cycles);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst_n            <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.command    <= CMD_NOP;
    in_if.address    <= 2'd0;
    in_if.write_data <= 8'h00;
    in_if.gate       <= 1'b0;
    for (int i = 0; i < MAX_CHANNELS; i++) begin
      cnt_mode[i]   = MODE_ONESHOT;
      cnt_order[i]  = ORD_LATCH;
      wr_hi_next[i] = 1'b0;
      rd_hi_next[i] = 1'b0;
      reload_val[i] = '0;
      count_val[i]  = '0;
      snap_val[i]   = '0;
      snap_held[i]  = 1'b0;
      out_lvl[i]    = 1'b0;
      armed[i]      = 1'b0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_and_ignored();
    test_one_shot_count();
    test_rate_generator();
    test_square_wave_and_latch();
    test_random_traffic();

    in_if.valid <= 1'b0;
    while (predicted_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
